@@ src/eint_pkg.sv @@
// package for the eased interpolator: easing curve codes and the cosine
// table generator used at elaboration time
// no dependencies
`timescale 1ns / 1ps

package eint_pkg;

	localparam int CURVE_BITS = 3;

	typedef enum logic [CURVE_BITS-1:0] {
		EASE_TRUNC   = 3'd0,
		EASE_LINEAR  = 3'd1,
		EASE_COSINE  = 3'd2,
		EASE_CUBIC   = 3'd3,
		EASE_QUINTIC = 3'd4
	} easing_t;

	// pi in q30
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// term * y2 in q30, rounded
	function automatic logic [63:0] q30_mul(input logic [63:0] x, input logic [63:0] y);
		return (x * y + (64'd1 << 29)) >> 30;
	endfunction

	// one entry of the (1 - cos(pi*w)) / 2 table, computed as sin^2 of half the angle
	// by a truncated taylor series; idx < 2^c, result in q0.f clamped to one
	function automatic logic [63:0] cos_entry(input logic [63:0] idx, input int c,
						  input int f);
		logic [63:0] n;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] term;
		logic [63:0] sq;
		logic [63:0] e;
		logic signed [63:0] s;
		n = 64'd1 << c;
		y = (PI_Q30 * idx + n) >> (c + 1);
		y2 = q30_mul(y, y);
		term = y;
		s = $signed(y);
		term = q30_mul(term, y2) / 64'd6;   s = s - $signed(term);
		term = q30_mul(term, y2) / 64'd20;  s = s + $signed(term);
		term = q30_mul(term, y2) / 64'd42;  s = s - $signed(term);
		term = q30_mul(term, y2) / 64'd72;  s = s + $signed(term);
		term = q30_mul(term, y2) / 64'd110; s = s - $signed(term);
		term = q30_mul(term, y2) / 64'd156; s = s + $signed(term);
		term = q30_mul(term, y2) / 64'd210; s = s - $signed(term);
		term = q30_mul(term, y2) / 64'd272; s = s + $signed(term);
		if (s < 0)
			s = 64'sd0;
		if (s > (64'sd1 <<< 30))
			s = 64'sd1 <<< 30;
		sq = $unsigned(s) * $unsigned(s);
		e = (sq + (64'd1 << (59 - f))) >> (60 - f);
		if (e > (64'd1 << f))
			e = 64'd1 << f;
		return e;
	endfunction

endpackage

@@ src/eased_interpolator_unit.sv @@
// Eased interpolator: blends two signed samples by an eased weight.
//
// Channels: one request per cycle on the slave stream (s_tvalid/s_tready/s_tdata),
// one result per request on the master stream (m_tvalid/m_tready/m_tdata).
// A request is accepted on a rising edge with tvalid and tready both high.
// The easing curve register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the unit is idle, and the unit does not enforce this:
// 0 truncate, 1 linear, 2 cosine, 3 smoothstep, 4 smootherstep, 5 to 7 act as
// linear. The pipeline has nine register stages; its multiplier chain is w*w,
// w^3 and cubic, w^3*p, then the blend, and m_tvalid is the last stage's valid.
// Throughput: one request per cycle, sustained while m_tready stays high.
// The cosine table is a 2^COS_TABLE_BITS entry rom with a registered read in
// stage two; weight one is served without the rom.
// Reset clears all stage valid bits and sets the curve to linear; no clearing pass.
// Stall: every stage holds its item while the next one is full, and a stage
// takes a new item as soon as it is empty or moving on, so bubbles close up and
// requests keep being accepted until all nine stages are full.
// Depends on eint_pkg.
`timescale 1ns / 1ps

module eased_interpolator_unit #(
	parameter int SAMPLE_BITS      = 16,
	parameter int WEIGHT_FRAC_BITS = 16,
	parameter int COS_TABLE_BITS   = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// start_value, end_value, weight (lowest bit first), zero padded to bytes
	input  logic [((2*SAMPLE_BITS+WEIGHT_FRAC_BITS+1+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// blended_value, zero padded to bytes
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	input  logic cfg_wr_en,
	input  logic [eint_pkg::CURVE_BITS-1:0] cfg_wr_data
);

	localparam int S = SAMPLE_BITS;
	localparam int F = WEIGHT_FRAC_BITS;
	localparam int C = COS_TABLE_BITS;
	localparam int TW = F + 1;
	localparam int OUT_W = ((S + 7) / 8) * 8;
	localparam int COS_N = 1 << C;

	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
	localparam logic [2*F+4:0] HALF = (2*F+5)'(1) << (F - 1);
	localparam logic [S+F:0] HALF_B = (S+F+1)'(1) << (F - 1);
	localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
	localparam logic [2*F+4:0] TEN_ONE_SQ = ((2*F+5)'(1) << (2*F+3)) +
						((2*F+5)'(1) << (2*F+1));
	localparam logic [F+3:0] P_MAX = (F+4)'(10) << F;

	typedef logic [F:0] cos_rom_t [COS_N];

	function automatic cos_rom_t build_cos_rom();
		cos_rom_t r;
		for (int i = 0; i < COS_N; i++)
			r[i] = TW'(eint_pkg::cos_entry(64'(i), C, F));
		return r;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

	logic [eint_pkg::CURVE_BITS-1:0] curve_q;

	// input field slices
	logic [S-1:0] a_in;
	logic [S-1:0] b_in;
	logic [F:0]   w_in;
	logic [S:0]   diff_in;
	assign a_in = s_tdata[S-1:0];
	assign b_in = s_tdata[2*S-1:S];
	assign w_in = s_tdata[2*S+F:2*S];
	assign diff_in = {b_in[S-1], b_in} - {a_in[S-1], a_in};

	// stage valid and ready
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	assign rdy_s9 = !vld_s9 || m_tready;
	assign rdy_s8 = !vld_s8 || rdy_s9;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// payload registers
	logic [S-1:0]   a_s1, a_s2, a_s3, a_s4, a_s5, a_s6, a_s7, a_s8;
	logic           neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [S-1:0]   mag_s2, mag_s3, mag_s4, mag_s5, mag_s6, mag_s7, mag_s8;
	logic [S:0]     diff_s1;
	logic [F:0]     w_s1, w_s2, w_s3, w_s4, w_s5, w_s6;
	logic [2*F:0]   ww_s2;
	logic [F:0]     rom_s2;
	logic           cfull_s2;
	logic [F:0]     cos_s3, cos_s4, cos_s5, cos_s6;
	logic [F:0]     w2_s3;
	logic [F+3:0]   p_s3, p_s4, p_s5;
	logic [F+1:0]   fac3_s3;
	logic [2*F+1:0] pw3_s4;
	logic [2*F+2:0] pc_s4;
	logic [F:0]     w3_s5;
	logic [F:0]     tc_s5, tc_s6;
	logic [2*F+4:0] pq_s6;
	logic [F:0]     t_s7;
	logic [S+F:0]   pb_s8;
	logic [S-1:0]   res_s9;

	// stage 1 combinational: cosine rom index
	logic [C-1:0] cidx;
	generate
		if (F >= C) begin : g_idx_shr
			assign cidx = w_s1[F-1 -: C];
		end else begin : g_idx_shl
			assign cidx = {w_s1[F-1:0], {(C-F){1'b0}}};
		end
	endgenerate

	logic [S:0] negd;
	assign negd = ~diff_s1 + (S+1)'(1);

	// stage 3 combinational: w^2, quintic factor, cubic factor
	logic [2*F:0]   w2_sum;
	logic [2*F+4:0] ww_x;
	logic [2*F+4:0] w_x;
	logic [2*F+4:0] p_sum;
	assign w2_sum = ww_s2 + HALF[2*F:0];
	assign ww_x = (2*F+5)'(ww_s2);
	assign w_x = (2*F+5)'(w_s2);
	// 6*w*w + 10*one*one - 15*w*one, always positive on [0, one]
	assign p_sum = (ww_x << 2) + (ww_x << 1) + TEN_ONE_SQ
		     - (((w_x << 4) - w_x) << F) + HALF;

	// stage 5 combinational
	logic [2*F+1:0] w3_sum;
	logic [2*F+2:0] tc_sum;
	logic [F+1:0]   tc_raw;
	assign w3_sum = pw3_s4 + HALF[2*F+1:0];
	assign tc_sum = pc_s4 + HALF[2*F+2:0];
	assign tc_raw = tc_sum[2*F+1:F];

	// stage 7 combinational: quintic result and curve select
	logic [2*F+4:0] tq_sum;
	logic [F+4:0]   tq_raw;
	logic [F:0]     tq;
	logic [F:0]     t_sel;
	assign tq_sum = pq_s6 + HALF;
	assign tq_raw = tq_sum[2*F+4:F];
	assign tq = (tq_raw > (F+5)'(ONE)) ? ONE : tq_raw[F:0];

	always_comb begin
		case (curve_q)
			eint_pkg::EASE_TRUNC:   t_sel = '0;
			eint_pkg::EASE_COSINE:  t_sel = cos_s6;
			eint_pkg::EASE_CUBIC:   t_sel = tc_s6;
			eint_pkg::EASE_QUINTIC: t_sel = tq;
			default:                t_sel = w_s6;
		endcase
	end

	// stage 9 combinational: rounded offset and blend
	logic [S+F:0] q_sum;
	logic [S-1:0] q;
	assign q_sum = pb_s8 + HALF_B;
	assign q = q_sum[S+F-1:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q <= eint_pkg::EASE_LINEAR;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (cfg_wr_en)
				curve_q <= cfg_wr_data;
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
			if (rdy_s9) vld_s9 <= vld_s8;
		end
	end

	// cosine rom, registered read
	always_ff @(posedge clk) begin
		if (rdy_s2)
			rom_s2 <= COS_ROM[cidx];
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			a_s1 <= a_in;
			diff_s1 <= diff_in;
			w_s1 <= (w_in > ONE) ? ONE : w_in;
		end
		if (rdy_s2) begin
			a_s2 <= a_s1;
			neg_s2 <= diff_s1[S];
			mag_s2 <= diff_s1[S] ? negd[S-1:0] : diff_s1[S-1:0];
			w_s2 <= w_s1;
			ww_s2 <= (2*F+1)'((2*F+2)'(w_s1) * (2*F+2)'(w_s1));
			cfull_s2 <= (w_s1 == ONE);
		end
		if (rdy_s3) begin
			a_s3 <= a_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			w_s3 <= w_s2;
			cos_s3 <= cfull_s2 ? ONE : rom_s2;
			w2_s3 <= w2_sum[2*F:F];
			p_s3 <= p_sum[2*F+3:F];
			fac3_s3 <= THREE_ONE - {w_s2, 1'b0};
		end
		if (rdy_s4) begin
			a_s4 <= a_s3;
			neg_s4 <= neg_s3;
			mag_s4 <= mag_s3;
			w_s4 <= w_s3;
			cos_s4 <= cos_s3;
			p_s4 <= p_s3;
			pw3_s4 <= (2*F+2)'(w2_s3) * (2*F+2)'(w_s3);
			pc_s4 <= (2*F+3)'(w2_s3) * (2*F+3)'(fac3_s3);
		end
		if (rdy_s5) begin
			a_s5 <= a_s4;
			neg_s5 <= neg_s4;
			mag_s5 <= mag_s4;
			w_s5 <= w_s4;
			cos_s5 <= cos_s4;
			p_s5 <= p_s4;
			w3_s5 <= w3_sum[2*F:F];
			tc_s5 <= (tc_raw > (F+2)'(ONE)) ? ONE : tc_raw[F:0];
		end
		if (rdy_s6) begin
			a_s6 <= a_s5;
			neg_s6 <= neg_s5;
			mag_s6 <= mag_s5;
			w_s6 <= w_s5;
			cos_s6 <= cos_s5;
			tc_s6 <= tc_s5;
			pq_s6 <= (2*F+5)'(w3_s5) * (2*F+5)'(p_s5);
		end
		if (rdy_s7) begin
			a_s7 <= a_s6;
			neg_s7 <= neg_s6;
			mag_s7 <= mag_s6;
			t_s7 <= t_sel;
		end
		if (rdy_s8) begin
			a_s8 <= a_s7;
			neg_s8 <= neg_s7;
			mag_s8 <= mag_s7;
			pb_s8 <= (S+F+1)'(mag_s7) * (S+F+1)'(t_s7);
		end
		if (rdy_s9)
			res_s9 <= neg_s8 ? (a_s8 - q) : (a_s8 + q);
	end

	assign m_tvalid = vld_s9;
	assign m_tdata = OUT_W'(res_s9);

	// input held back only when every stage is occupied and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 &&
			       vld_s7 && vld_s8 && vld_s9 && !m_tready))
		else $error("input stalled while the pipeline has room");

	// quintic factor lies between one and ten
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ((p_s3 >= (F+4)'(ONE)) && (p_s3 <= P_MAX)))
		else $error("quintic factor out of range");

	// eased weight never exceeds one
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> (t_s7 <= ONE))
		else $error("eased weight above one");

	// rounded offset never passes the end sample
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> (q <= mag_s8))
		else $error("blend offset larger than sample distance");

endmodule
